FILE: hdl/lcs_pkg.sv
package lcs_pkg;

    // input command codes
    localparam logic CMD_FIRST  = 1'b0;
    localparam logic CMD_SECOND = 1'b1;

    // similarity format: unsigned 1.16, the integer bit only for the value one
    localparam int SIM_FRAC_W = 16;
    localparam int SIM_W      = SIM_FRAC_W + 1;
    localparam logic [SIM_W-1:0] SIM_ONE = SIM_W'(1) << SIM_FRAC_W;

    // divider step counter, one quotient bit per step
    localparam int DIV_STEP_W = $clog2(SIM_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_RES,
        ST_DIVIDE,
        ST_HOLD
    } lcs_state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic div_start;
        logic out_load;
    } lcs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic item_result;
        logic item_scan;
        logic scan_busy;
        logic div_busy;
        logic out_valid;
    } lcs_status_t;

endpackage

FILE: hdl/lcs_similarity_top.sv
// a first-string request is taken without leaving the idle state; a second-string byte that updates the row
// runs through its m cells, m being the first-string length, one row cell per cycle
// a last request starts the bit-serial divider for the similarity once any row update is
// done, one quotient bit per step; the divider is skipped if either string is empty
// a new request is taken while a finished result waits in the output register
// reset is synchronous, active low: counts, flags and handshakes clear, no clearing pass
module lcs_similarity_top
    import lcs_pkg::*;
#(
    parameter int MAX_LEN = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_cmd,
    input  logic [7:0]                     s_symbol,
    input  logic                           s_has_symbol,
    input  logic                           s_last,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [$clog2(MAX_LEN+1)-1:0]   m_lcs_length,
    output logic [SIM_W-1:0]               m_similarity,
    output logic                           m_overflow
);

    lcs_cmd_t    ctrl;
    lcs_status_t status;

    // sequencing
    lcs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .status  (status),
        .ctrl    (ctrl)
    );

    // storage, row update, divider and output register
    lcs_datapath #(.MAX_LEN(MAX_LEN)) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_cmd        (s_cmd),
        .s_symbol     (s_symbol),
        .s_has_symbol (s_has_symbol),
        .s_last       (s_last),
        .ctrl         (ctrl),
        .status       (status),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_lcs_length (m_lcs_length),
        .m_similarity (m_similarity),
        .m_overflow   (m_overflow)
    );

endmodule

FILE: hdl/lcs_ram.sv
module lcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/lcs_ctrl.sv
module lcs_ctrl
    import lcs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        m_ready,
    input  lcs_status_t status,
    output lcs_cmd_t    ctrl
);

    lcs_state_t state_reg;
    lcs_state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        ctrl       = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctrl.accept = 1'b1;
                    if (status.item_result) begin
                        state_next = ST_SCAN_RES;
                    end else if (status.item_scan) begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (!status.scan_busy) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN_RES: begin
                if (!status.scan_busy) begin
                    ctrl.div_start = 1'b1;
                    state_next     = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (!status.div_busy) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (!status.out_valid || m_ready) begin
                    ctrl.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/lcs_datapath.sv
module lcs_datapath
    import lcs_pkg::*;
#(
    parameter int MAX_LEN = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_cmd,
    input  logic [7:0]                     s_symbol,
    input  logic                           s_has_symbol,
    input  logic                           s_last,
    input  lcs_cmd_t                       ctrl,
    output lcs_status_t                    status,
    input  logic                           m_ready,
    output logic                           m_valid,
    output logic [$clog2(MAX_LEN+1)-1:0]   m_lcs_length,
    output logic [SIM_W-1:0]               m_similarity,
    output logic                           m_overflow
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int AW = MAX_LEN > 1 ? $clog2(MAX_LEN) : 1;
    localparam int DW = CW + 1;

    // string bookkeeping
    logic [CW-1:0] first_count_reg, first_count_next;
    logic [CW-1:0] second_count_reg, second_count_next;
    logic          first_ovf_reg, first_ovf_next;
    logic          second_ovf_reg, second_ovf_next;
    logic          first_closed_reg, first_closed_next;
    logic [CW-1:0] lcs_reg, lcs_next;

    // scan pipeline
    logic          issue_act_reg;
    logic [AW-1:0] issue_idx_reg;
    logic          c_act_reg;
    logic [AW-1:0] c_idx_reg;
    logic [7:0]    sym_reg;
    logic          first_pass_reg;
    logic [CW-1:0] left_reg;
    logic [CW-1:0] diag_reg;

    // divider and result
    logic                  div_act_reg;
    logic [DIV_STEP_W-1:0] step_reg;
    logic [DW-1:0]         divisor_reg;
    logic [DW-1:0]         rem_reg;
    logic [SIM_W-1:0]      quo_reg;
    logic [CW-1:0]         res_len_reg;
    logic                  res_ovf_reg;
    logic                  m_valid_reg;
    logic [CW-1:0]         out_len_reg;
    logic [SIM_W-1:0]      out_sim_reg;
    logic                  out_ovf_reg;

    logic [CW-1:0] fc_base;
    logic [CW-1:0] n_base;
    logic          first_room;
    logic          second_room;
    logic          char_wr;
    logic          scan_go;
    logic [AW-1:0] last_idx;
    logic [7:0]    char_rd;
    logic [CW-1:0] row_rd;
    logic [CW-1:0] above;
    logic [CW-1:0] cell_new;
    logic [DW:0]   shifted;
    logic          div_ge;
    logic [DW:0]   div_diff;

    // counts as seen by the incoming request, after any implicit restart
    assign fc_base     = first_closed_reg ? '0 : first_count_reg;
    assign n_base      = first_closed_reg ? second_count_reg : '0;
    assign first_room  = fc_base < CW'(MAX_LEN);
    assign second_room = n_base < CW'(MAX_LEN);
    assign char_wr     = ctrl.accept && (s_cmd == CMD_FIRST) && s_has_symbol && first_room;
    assign scan_go     = (s_cmd == CMD_SECOND) && s_has_symbol && second_room
                         && (first_count_reg != '0);
    assign last_idx    = AW'(first_count_reg - CW'(1));

    assign status.item_result = (s_cmd == CMD_SECOND) && s_last;
    assign status.item_scan   = scan_go;
    assign status.scan_busy   = issue_act_reg || c_act_reg;
    assign status.div_busy    = div_act_reg;
    assign status.out_valid   = m_valid_reg;

    // first string store
    lcs_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_char_ram (
        .aclk    (aclk),
        .wr_en   (char_wr),
        .wr_addr (fc_base[AW-1:0]),
        .wr_data (s_symbol),
        .rd_en   (issue_act_reg),
        .rd_addr (issue_idx_reg),
        .rd_data (char_rd)
    );

    // dynamic-programming row, entry k holds the length for prefix k+1
    lcs_ram #(.WIDTH(CW), .DEPTH(MAX_LEN)) u_row_ram (
        .aclk    (aclk),
        .wr_en   (c_act_reg),
        .wr_addr (c_idx_reg),
        .wr_data (cell_new),
        .rd_en   (issue_act_reg),
        .rd_addr (issue_idx_reg),
        .rd_data (row_rd)
    );

    // one cell of the row update; the first pass after a clear sees zeros
    assign above    = first_pass_reg ? '0 : row_rd;
    assign cell_new = (char_rd == sym_reg) ? diag_reg + CW'(1)
                    : (left_reg > above) ? left_reg : above;

    // restoring division step
    assign shifted  = {rem_reg, 1'b0};
    assign div_ge   = shifted >= {1'b0, divisor_reg};
    assign div_diff = shifted - {1'b0, divisor_reg};

    // string bookkeeping next values
    always_comb begin
        first_count_next  = first_count_reg;
        second_count_next = second_count_reg;
        first_ovf_next    = first_ovf_reg;
        second_ovf_next   = second_ovf_reg;
        first_closed_next = first_closed_reg;
        lcs_next          = lcs_reg;
        if (c_act_reg && (c_idx_reg == last_idx)) begin
            lcs_next = cell_new;
        end
        if (ctrl.accept) begin
            if (s_cmd == CMD_FIRST) begin
                if (first_closed_reg) begin
                    first_count_next  = '0;
                    second_count_next = '0;
                    first_ovf_next    = 1'b0;
                    second_ovf_next   = 1'b0;
                    first_closed_next = 1'b0;
                    lcs_next          = '0;
                end
                if (s_has_symbol) begin
                    if (first_room) begin
                        first_count_next = fc_base + CW'(1);
                    end else begin
                        first_ovf_next = 1'b1;
                    end
                end
                if (s_last) begin
                    first_closed_next = 1'b1;
                    second_count_next = '0;
                    lcs_next          = '0;
                end
            end else begin
                first_closed_next = 1'b1;
                if (!first_closed_reg) begin
                    second_count_next = '0;
                    lcs_next          = '0;
                end
                if (s_has_symbol) begin
                    if (second_room) begin
                        second_count_next = n_base + CW'(1);
                    end else begin
                        second_ovf_next = 1'b1;
                    end
                end
            end
        end
        if (ctrl.div_start) begin
            second_count_next = '0;
            second_ovf_next   = 1'b0;
            lcs_next          = '0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_count_reg  <= '0;
            second_count_reg <= '0;
            first_ovf_reg    <= 1'b0;
            second_ovf_reg   <= 1'b0;
            first_closed_reg <= 1'b1;
            lcs_reg          <= '0;
            issue_act_reg    <= 1'b0;
            c_act_reg        <= 1'b0;
            div_act_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            first_count_reg  <= first_count_next;
            second_count_reg <= second_count_next;
            first_ovf_reg    <= first_ovf_next;
            second_ovf_reg   <= second_ovf_next;
            first_closed_reg <= first_closed_next;
            lcs_reg          <= lcs_next;
            c_act_reg        <= issue_act_reg;
            if (ctrl.accept && scan_go) begin
                issue_act_reg <= 1'b1;
            end else if (issue_act_reg && (issue_idx_reg == last_idx)) begin
                issue_act_reg <= 1'b0;
            end
            if (ctrl.div_start) begin
                div_act_reg <= (first_count_reg != '0) && (second_count_reg != '0);
            end else if (div_act_reg && (step_reg == '0)) begin
                div_act_reg <= 1'b0;
            end
            if (ctrl.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // scan and divider payload
    always_ff @(posedge aclk) begin
        c_idx_reg <= issue_idx_reg;
        if (ctrl.accept && scan_go) begin
            issue_idx_reg  <= '0;
            sym_reg        <= s_symbol;
            first_pass_reg <= (n_base == '0);
            left_reg       <= '0;
            diag_reg       <= '0;
        end else begin
            if (issue_act_reg) begin
                issue_idx_reg <= issue_idx_reg + AW'(1);
            end
            if (c_act_reg) begin
                left_reg <= cell_new;
                diag_reg <= above;
            end
        end
        if (ctrl.div_start) begin
            step_reg    <= DIV_STEP_W'(SIM_W - 1);
            divisor_reg <= DW'(first_count_reg) + DW'(second_count_reg);
            rem_reg     <= DW'(lcs_reg);
            quo_reg     <= '0;
            res_len_reg <= lcs_reg;
            res_ovf_reg <= first_ovf_reg || second_ovf_reg;
        end else if (div_act_reg) begin
            step_reg <= step_reg - DIV_STEP_W'(1);
            rem_reg  <= div_ge ? div_diff[DW-1:0] : shifted[DW-1:0];
            quo_reg  <= {quo_reg[SIM_W-2:0], div_ge};
        end
        if (ctrl.out_load) begin
            out_len_reg <= res_len_reg;
            out_sim_reg <= quo_reg;
            out_ovf_reg <= res_ovf_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_lcs_length = out_len_reg;
    assign m_similarity = out_sim_reg;
    assign m_overflow   = out_ovf_reg;

`ifndef SYNTHESIS
    // a cell is only ever written inside the first string
    a_cell_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        c_act_reg |-> ({1'b0, c_idx_reg} < {1'b0, first_count_reg}))
        else $error("row cell written beyond first string");

    // division never starts while the row is still being updated
    a_div_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.div_start |-> !(issue_act_reg || c_act_reg))
        else $error("division started during scan");

    // a running division never has a zero divisor
    a_divisor_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        div_act_reg |-> (divisor_reg != '0))
        else $error("division by zero");

    // similarity never exceeds one
    a_sim_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (out_sim_reg <= SIM_ONE))
        else $error("similarity above one");
`endif

endmodule

FILE: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lcs_pkg::*;

    localparam int MAX_LEN     = 64;
    localparam int LEN_W       = $clog2(MAX_LEN + 1);
    localparam int ITEM_TARGET = 1200;
    localparam int IDLE_PCT    = 31;
    localparam int DRAIN_WAIT  = 100;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [SIM_W-1:0] sim;
        logic             ovf;
    } score_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] symbol;
        logic       has_symbol;
        logic       last;
        logic       typed;
        score_t     score;
    } stim_row_t;

    localparam score_t NO_SCORE = '0;

    logic             aclk         = 1'b0;
    logic             aresetn      = 1'b0;
    logic             s_valid      = 1'b0;
    logic             s_ready;
    logic             s_cmd        = CMD_FIRST;
    logic [7:0]       s_symbol     = 8'h00;
    logic             s_has_symbol = 1'b0;
    logic             s_last       = 1'b0;
    logic             m_valid;
    logic             m_ready      = 1'b0;
    logic [LEN_W-1:0] m_lcs_length;
    logic [SIM_W-1:0] m_similarity;
    logic             m_overflow;

    // predictor state: stored first string and the dp row
    logic [7:0]       a_chars [MAX_LEN];
    logic [LEN_W-1:0] dp_row [MAX_LEN+1];
    int unsigned      a_len    = 0;
    int unsigned      b_len    = 0;
    bit               a_ovf    = 1'b0;
    bit               b_ovf    = 1'b0;
    bit               a_closed = 1'b1;

    score_t    pending_scores [$];
    score_t    want;
    stim_row_t directed_rows [0:17];
    int        errors     = 0;
    int        items_sent = 0;
    bit        calm       = 1'b0;

    always #1 aclk = ~aclk;

    lcs_similarity_top #(
        .MAX_LEN(MAX_LEN)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_cmd(s_cmd),
        .s_symbol(s_symbol),
        .s_has_symbol(s_has_symbol),
        .s_last(s_last),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_lcs_length(m_lcs_length),
        .m_similarity(m_similarity),
        .m_overflow(m_overflow)
    );

    // reset the row ahead of a fresh comparison
    function automatic void clear_dp();
        for (int i = 0; i <= MAX_LEN; i++) begin
            dp_row[i] = '0;
        end
        b_len = 0;
    endfunction

    // one request through the predictor, returns 1 when it yields a score
    function automatic bit lcs_step(input stim_row_t row, output score_t res);
        logic [LEN_W-1:0] diag;
        logic [LEN_W-1:0] above;
        longint unsigned  num;
        res = NO_SCORE;
        if (row.cmd == CMD_FIRST) begin
            if (a_closed) begin
                a_len    = 0;
                a_ovf    = 1'b0;
                b_ovf    = 1'b0;
                a_closed = 1'b0;
                clear_dp();
            end
            if (row.has_symbol) begin
                if (a_len < MAX_LEN) begin
                    a_chars[a_len] = row.symbol;
                    a_len++;
                end else begin
                    a_ovf = 1'b1;
                end
            end
            if (row.last) begin
                a_closed = 1'b1;
                clear_dp();
            end
            return 1'b0;
        end
        // second string closes an open first string
        if (!a_closed) begin
            a_closed = 1'b1;
            clear_dp();
        end
        if (row.has_symbol) begin
            if (b_len < MAX_LEN) begin
                diag = dp_row[0];
                for (int i = 1; i <= a_len; i++) begin
                    above = dp_row[i];
                    if (a_chars[i-1] == row.symbol) begin
                        dp_row[i] = diag + 1'b1;
                    end else if (dp_row[i-1] > above) begin
                        dp_row[i] = dp_row[i-1];
                    end
                    diag = above;
                end
                b_len++;
            end else begin
                b_ovf = 1'b1;
            end
        end
        if (!row.last) begin
            return 1'b0;
        end
        res.len = dp_row[a_len];
        num = 0;
        if (a_len > 0 && b_len > 0) begin
            num = (longint'(2) * dp_row[a_len] * 65536) / (a_len + b_len);
        end
        res.sim = num[SIM_W-1:0];
        res.ovf = a_ovf | b_ovf;
        clear_dp();
        b_ovf = 1'b0;
        return 1'b1;
    endfunction

    function automatic stim_row_t make_row(input logic cmd, input logic [7:0] sym,
                                           input logic has, input logic last);
        stim_row_t row;
        row            = '0;
        row.cmd        = cmd;
        row.symbol     = sym;
        row.has_symbol = has;
        row.last       = last;
        return row;
    endfunction

    // mostly short strings, some mid-length, a few around and past the store size
    function automatic int unsigned pick_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            return $urandom_range(0, 8);
        end else if (roll < 90) begin
            return $urandom_range(9, 30);
        end
        return $urandom_range(MAX_LEN - 4, MAX_LEN + 6);
    endfunction

    // drive one request, gaps before it, and log its expected score
    task automatic send_item(input stim_row_t row);
        score_t predicted;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= row.cmd;
        s_symbol     <= row.symbol;
        s_has_symbol <= row.has_symbol;
        s_last       <= row.last;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        if (lcs_step(row, predicted)) begin
            pending_scores.push_back(row.typed ? row.score : predicted);
        end
        if (row.has_symbol || row.last) begin
            items_sent++;
        end
        @(negedge aclk);
    endtask

    // one string, with the odd stray marker mixed in
    task automatic send_string(input logic cmd, input int unsigned len, input bit wide,
                               input bit closing);
        logic [7:0] sym;
        if (len == 0 && closing) begin
            send_item(make_row(cmd, 8'($urandom), 1'b0, 1'b1));
        end
        for (int unsigned k = 0; k < len; k++) begin
            if ($urandom_range(0, 24) == 0) begin
                send_item(make_row(cmd, 8'($urandom), 1'b0, 1'b0));
            end
            sym = wide ? 8'($urandom) : 8'($urandom_range(8'h61, 8'h64));
            send_item(make_row(cmd, sym, 1'b1, closing && (k == len - 1)));
        end
    endtask

    // result side: random back-pressure except in the calm stretch
    always @(negedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // compare every accepted score with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_scores.size() == 0) begin
                $display("%0t: unexpected score len=%0d sim=%0d ovf=%0b", $time,
                         m_lcs_length, m_similarity, m_overflow);
                errors++;
            end else begin
                want = pending_scores.pop_front();
                if (m_lcs_length !== want.len) begin
                    $display("%0t: lcs_length expected %0d got %0d", $time,
                             want.len, m_lcs_length);
                    errors++;
                end
                if (m_similarity !== want.sim) begin
                    $display("%0t: similarity expected %0d got %0d", $time,
                             want.sim, m_similarity);
                    errors++;
                end
                if (m_overflow !== want.ovf) begin
                    $display("%0t: overflow expected %0b got %0b", $time,
                             want.ovf, m_overflow);
                    errors++;
                end
            end
        end
    end

    initial begin
        int unsigned roll;
        bit          wide;
        // directed part: fixed scores where they are obvious
        directed_rows = '{
            // comparison against an empty first string straight after reset
            '{CMD_SECOND, 8'h41, 1'b1, 1'b1, 1'b1, '{7'd0, 17'd0, 1'b0}},
            '{CMD_FIRST,  8'h00, 1'b1, 1'b0, 1'b0, NO_SCORE},
            '{CMD_FIRST,  8'hFF, 1'b1, 1'b1, 1'b0, NO_SCORE},
            '{CMD_SECOND, 8'hFF, 1'b1, 1'b0, 1'b0, NO_SCORE},
            '{CMD_SECOND, 8'h00, 1'b1, 1'b1, 1'b1, '{7'd1, 17'd32768, 1'b0}},
            // same first string kept for the next comparison
            '{CMD_SECOND, 8'h00, 1'b1, 1'b0, 1'b0, NO_SCORE},
            '{CMD_SECOND, 8'hFF, 1'b1, 1'b1, 1'b1, '{7'd2, 17'd65536, 1'b0}},
            // empty second string, symbol ignored
            '{CMD_SECOND, 8'hA5, 1'b0, 1'b1, 1'b1, '{7'd0, 17'd0, 1'b0}},
            // stray marker does nothing
            '{CMD_SECOND, 8'h5A, 1'b0, 1'b0, 1'b0, NO_SCORE},
            '{CMD_SECOND, 8'hAA, 1'b1, 1'b1, 1'b1, '{7'd0, 17'd0, 1'b0}},
            // empty first string
            '{CMD_FIRST,  8'hC3, 1'b0, 1'b1, 1'b0, NO_SCORE},
            '{CMD_SECOND, 8'h55, 1'b1, 1'b1, 1'b1, '{7'd0, 17'd0, 1'b0}},
            // first string left open, closed by the second string
            '{CMD_FIRST,  8'h3C, 1'b0, 1'b0, 1'b0, NO_SCORE},
            '{CMD_FIRST,  8'h12, 1'b1, 1'b0, 1'b0, NO_SCORE},
            '{CMD_FIRST,  8'h34, 1'b1, 1'b0, 1'b0, NO_SCORE},
            '{CMD_SECOND, 8'h34, 1'b1, 1'b1, 1'b1, '{7'd1, 17'd43690, 1'b0}},
            '{CMD_SECOND, 8'h12, 1'b1, 1'b0, 1'b0, NO_SCORE},
            '{CMD_SECOND, 8'h34, 1'b1, 1'b1, 1'b1, '{7'd2, 17'd65536, 1'b0}}
        };
        clear_dp();

        // reset
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i]);
        end

        // random part: mostly proper string pairs, some broken sequences
        while (items_sent < ITEM_TARGET) begin
            calm = (items_sent >= 500 && items_sent < 700);
            wide = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 85) begin
                send_string(CMD_FIRST, pick_len(), wide, 1'b1);
                repeat ($urandom_range(1, 3)) begin
                    send_string(CMD_SECOND, pick_len(), wide, 1'b1);
                end
            end else if (roll < 93) begin
                send_string(CMD_FIRST, $urandom_range(1, 6), wide, 1'b0);
                send_string(CMD_SECOND, pick_len(), wide, 1'b1);
            end else begin
                // second string cut short: a following first string drops it, a following cut-short one extends it
                send_string(CMD_SECOND, $urandom_range(1, 5), wide, 1'b0);
            end
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        // drain outstanding scores, then a short pause
        while (pending_scores.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
hdl/lcs_pkg.sv
hdl/lcs_ram.sv
hdl/lcs_ctrl.sv
hdl/lcs_datapath.sv
hdl/lcs_similarity_top.sv
tb/tb.sv
